@@ rtl/lpai_pkg.sv @@
// lpai_pkg: shared types and constants of the lens position / angle interpolator
// operation and register codes, sequencer states, divider status
// no dependencies
`default_nettype none

package lpai_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIV_STEPS = VAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // operation codes carried in tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_AD2ANG = 2'd1;
    localparam logic [1:0] OP_ANG2AD = 2'd2;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] REG_AD_ASC      = 2'd1;
    localparam logic [1:0] REG_CORR_EN     = 2'd2;
    localparam logic [1:0] REG_REF_AD      = 2'd3;

    localparam logic [6:0] ENTRY_COUNT_RST = 7'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/lpai_div.sv @@
// lpai_div: restoring divider, one quotient bit per cycle
// needs dividend / divisor below 2^VAL_W; uses lpai_pkg
`default_nettype none

module lpai_div
    import lpai_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [VAL_W-1:0]  divisor,
    output div_stat_t              stat,
    output logic      [VAL_W-1:0]  quotient,
    output logic                   rem_nz
);

    logic [VAL_W-1:0]     rem_reg;
    logic [VAL_W-1:0]     quo_reg;
    logic [VAL_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [VAL_W:0]       shifted;
    logic                 ge;
    logic [VAL_W:0]       diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[VAL_W-1]};
        ge      = shifted >= {1'b0, div_reg};
        diff    = shifted - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:VAL_W];
            quo_reg <= dividend[VAL_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign rem_nz    = rem_reg != '0;

endmodule

`default_nettype wire

@@ rtl/lens_position_angle_interpolator_top.sv @@
// lens position / angle interpolator: a load is written to the tables when taken; a query
// that ends at an end entry passes ST_FIRST, ST_LAST and ST_OUT, an interpolated one
// also ST_SCAN, ST_MUL, ST_DIVGO and ST_DIV before ST_OUT; one request at a time,
// the next taken once the result is registered, query time being set by the scan through
// the table memory read port and the 16-step serial divider; reset clears the
// configuration registers to defaults; the table memories are undefined until loaded
`default_nettype none

module lens_position_angle_interpolator_top
    import lpai_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[5:0], entry_ad[21:6], entry_angle[37:22], query_value[53:38], zero
    input  wire logic [55:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    // result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_value[15:0], telephoto_ad[31:16], wide_ad[47:32]
    output logic [47:0]      m_tdata,
    // clamped[0]
    output logic [0:0]       m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [6:0]       entry_count_reg;
    logic             ad_asc_reg;
    logic             corr_en_reg;
    logic [VAL_W-1:0] ref_ad_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
            ad_asc_reg      <= 1'b0;
            corr_en_reg     <= 1'b0;
            ref_ad_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENTRY_COUNT: entry_count_reg <= pwdata[6:0];
                REG_AD_ASC:      ad_asc_reg      <= pwdata[0];
                REG_CORR_EN:     corr_en_reg     <= pwdata[0];
                REG_REF_AD:      ref_ad_reg      <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENTRY_COUNT: prdata = {25'd0, entry_count_reg};
            REG_AD_ASC:      prdata = {31'd0, ad_asc_reg};
            REG_CORR_EN:     prdata = {31'd0, corr_en_reg};
            REG_REF_AD:      prdata = {16'd0, ref_ad_reg};
        endcase
    end

    // entries in use, clamped to [2, TABLE_DEPTH]
    logic [NW-1:0] used_n;
    always_comb
    begin
        priority if (entry_count_reg < 7'd2)
            used_n = NW'(2);
        else if (32'(entry_count_reg) > TABLE_DEPTH)
            used_n = NW'(TABLE_DEPTH);
        else
            used_n = NW'(entry_count_reg);
    end

    // input fields
    logic [1:0]       in_op;
    logic [5:0]       in_idx;
    logic [VAL_W-1:0] in_ad;
    logic [VAL_W-1:0] in_ang;
    logic [VAL_W-1:0] in_q;
    assign in_op  = s_tuser;
    assign in_idx = s_tdata[5:0];
    assign in_ad  = s_tdata[21:6];
    assign in_ang = s_tdata[37:22];
    assign in_q   = s_tdata[53:38];

    logic in_acc;
    logic in_query;
    assign in_acc   = s_tvalid && s_tready;
    assign in_query = (in_op == OP_AD2ANG) || (in_op == OP_ANG2AD);

    state_t state_reg;
    state_t state_next;

    // table memories, one read port each with registered data
    logic [VAL_W-1:0] ad_mem  [TABLE_DEPTH];
    logic [VAL_W-1:0] ang_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rd_ad_reg;
    logic [VAL_W-1:0] rd_ang_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_wr;

    assign mem_wr = in_acc && (in_op == OP_LOAD) && (32'(in_idx) < TABLE_DEPTH);

    // loads are taken only in idle, so a query never reads an entry being written
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            ad_mem[AW'(in_idx)]  <= in_ad;
            ang_mem[AW'(in_idx)] <= in_ang;
        end
        rd_ad_reg  <= ad_mem[rd_addr];
        rd_ang_reg <= ang_mem[rd_addr];
    end

    // query context
    logic [1:0]       op_reg;
    logic [VAL_W-1:0] q_reg;
    logic [NW-1:0]    last_idx_reg;
    logic [NW-1:0]    scan_idx_reg;
    logic [NW-1:0]    scan_next;
    logic [VAL_W-1:0] off_reg;
    logic [VAL_W-1:0] first_ad_reg;
    logic [VAL_W-1:0] ang0_reg;
    logic [VAL_W-1:0] wide_ad_reg;
    logic [VAL_W-1:0] l_key_reg;
    logic [VAL_W-1:0] l_oth_reg;
    logic [VAL_W-1:0] r_key_reg;
    logic [VAL_W-1:0] r_oth_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0] n2_reg;
    logic             neg_reg;
    logic [VAL_W-1:0] res_reg;
    logic             clamp_reg;

    assign scan_next = scan_idx_reg + NW'(1);

    logic ad_mode;
    logic key_falling;
    assign ad_mode     = op_reg == OP_AD2ANG;
    assign key_falling = ad_mode && !ad_asc_reg;

    // current entry with the offset applied
    logic [VAL_W-1:0] cur_ad;
    logic [VAL_W-1:0] cur_key;
    logic [VAL_W-1:0] cur_oth;
    logic             scan_hit;
    always_comb
    begin
        cur_ad   = rd_ad_reg + off_reg;
        cur_key  = ad_mode ? cur_ad : rd_ang_reg;
        cur_oth  = ad_mode ? rd_ang_reg : cur_ad;
        scan_hit = (key_falling ? (q_reg >= cur_key) : (q_reg <= cur_key))
                   || (scan_idx_reg == last_idx_reg);
    end

    // end entry tests, last entry data on the read port
    logic             end_hit;
    logic             end_clamp;
    logic [VAL_W-1:0] end_val;
    always_comb
    begin
        end_hit   = 1'b0;
        end_clamp = 1'b0;
        end_val   = first_ad_reg;
        if (ad_mode)
        begin
            if (!ad_asc_reg)
            begin
                if (q_reg >= first_ad_reg)
                begin
                    end_hit   = 1'b1;
                    end_clamp = q_reg > first_ad_reg;
                    end_val   = ang0_reg;
                end
                else if (q_reg <= cur_ad)
                begin
                    end_hit   = 1'b1;
                    end_clamp = q_reg < cur_ad;
                    end_val   = rd_ang_reg;
                end
            end
            else
            begin
                if (q_reg <= first_ad_reg)
                begin
                    end_hit   = 1'b1;
                    end_clamp = q_reg < first_ad_reg;
                    end_val   = ang0_reg;
                end
                else if (q_reg >= cur_ad)
                begin
                    end_hit   = 1'b1;
                    end_clamp = q_reg > cur_ad;
                    end_val   = rd_ang_reg;
                end
            end
        end
        else
        begin
            if (q_reg >= rd_ang_reg)
            begin
                end_hit   = 1'b1;
                end_clamp = q_reg > rd_ang_reg;
                end_val   = cur_ad;
            end
            else if (q_reg <= ang0_reg)
            begin
                end_hit   = 1'b1;
                end_clamp = q_reg < ang0_reg;
                end_val   = first_ad_reg;
            end
        end
    end

    // result = r_oth + round(n1 * (l_oth - r_oth) / n2), ceiling for ad to angle
    logic [VAL_W-1:0] n1;
    logic [VAL_W-1:0] n2;
    logic [VAL_W:0]   e_diff;
    logic [VAL_W:0]   e_mag;
    always_comb
    begin
        n1     = key_falling ? (q_reg - r_key_reg) : (r_key_reg - q_reg);
        n2     = key_falling ? (l_key_reg - r_key_reg) : (r_key_reg - l_key_reg);
        e_diff = {1'b0, l_oth_reg} - {1'b0, r_oth_reg};
        e_mag  = e_diff[VAL_W] ? ((VAL_W + 1)'(0) - e_diff) : e_diff;
    end

    // divider
    logic             div_start;
    div_stat_t        div_stat;
    logic [VAL_W-1:0] div_quo;
    logic             div_rem_nz;

    lpai_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (n2_reg),
        .stat     (div_stat),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    logic             round_up;
    logic [VAL_W:0]   adj;
    logic [VAL_W-1:0] interp_res;
    always_comb
    begin
        round_up   = neg_reg ^ ad_mode;
        adj        = {1'b0, div_quo} + (VAL_W + 1)'(round_up && div_rem_nz);
        interp_res = neg_reg ? (r_oth_reg - adj[VAL_W-1:0]) : (r_oth_reg + adj[VAL_W-1:0]);
    end

    // output register
    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;
    logic             m_tuser_reg;
    logic             out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc && in_query) state_next = ST_FIRST;
            ST_FIRST: state_next = ST_LAST;
            ST_LAST:  state_next = end_hit ? ST_OUT : ST_SCAN;
            ST_SCAN:  if (scan_hit) state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIVGO;
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV:   if (div_stat.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        rd_addr   = '0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_FIRST: rd_addr   = last_idx_reg[AW-1:0];
            ST_LAST:  rd_addr   = AW'(1);
            ST_SCAN:  rd_addr   = scan_next[AW-1:0];
            ST_DIVGO: div_start = 1'b1;
            default:  rd_addr   = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_query)
                begin
                    op_reg       <= in_op;
                    q_reg        <= in_q;
                    last_idx_reg <= used_n - NW'(1);
                end
            end
            ST_FIRST:
            begin
                off_reg      <= corr_en_reg ? (ref_ad_reg - rd_ad_reg) : '0;
                first_ad_reg <= corr_en_reg ? ref_ad_reg : rd_ad_reg;
                ang0_reg     <= rd_ang_reg;
            end
            ST_LAST:
            begin
                wide_ad_reg  <= cur_ad;
                res_reg      <= end_val;
                clamp_reg    <= end_clamp;
                scan_idx_reg <= NW'(1);
                // entry 0 is the left end of the first pair
                l_key_reg    <= ad_mode ? first_ad_reg : ang0_reg;
                l_oth_reg    <= ad_mode ? ang0_reg : first_ad_reg;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    r_key_reg <= cur_key;
                    r_oth_reg <= cur_oth;
                end
                else
                begin
                    l_key_reg    <= cur_key;
                    l_oth_reg    <= cur_oth;
                    scan_idx_reg <= scan_next;
                end
            end
            ST_MUL:
            begin
                prod_reg  <= n1 * e_mag[VAL_W-1:0];
                n2_reg    <= n2;
                neg_reg   <= e_diff[VAL_W];
                clamp_reg <= 1'b0;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    res_reg <= interp_res;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {wide_ad_reg, first_ad_reg, res_reg};
                    m_tuser_reg <= clamp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the wait state");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (scan_idx_reg != '0) && (scan_idx_reg <= last_idx_reg))
        else $error("scan index outside the table in use");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && ((s_tuser == OP_AD2ANG) || (s_tuser == OP_ANG2AD)))
        |=> !s_tready)
        else $error("new request taken while a query is in progress");

endmodule

`default_nettype wire

@@ dv/lens_position_angle_interpolator_top_tb.sv @@
// testbench for lens_position_angle_interpolator_top: table loads, ad/angle lookups over apb settings
// a scoreboard class predicts every lookup result; needs lpai_pkg and the top level only
`timescale 1ns / 1ps

module lens_position_angle_interpolator_top_tb
    import lpai_pkg::*;
();

    localparam int          TBL_DEPTH     = TABLE_DEPTH_DEF;
    localparam logic [1:0]  OP_NONE       = 2'd3;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          CYCLE_LIMIT   = 1500000;
    localparam int          PHASES        = 16;
    localparam int          PHASE_ITEMS   = 55;

    typedef struct packed {
        logic [15:0] value;
        logic        clamped;
        logic [15:0] tele_ad;
        logic [15:0] wide_ad;
    } lookup_t;

    class interp_scoreboard;
        logic [15:0] ad_col [TBL_DEPTH];
        logic [15:0] ang_col [TBL_DEPTH];
        logic [6:0]  entry_count;
        logic        ad_rising;
        logic        corr_on;
        logic [15:0] ref_ad;
        lookup_t     expected_lookups [$];
        int          errors;

        function new();
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                ad_col[i]  = '0;
                ang_col[i] = '0;
            end
            entry_count = ENTRY_COUNT_RST;
            ad_rising   = 1'b0;
            corr_on     = 1'b0;
            ref_ad      = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ENTRY_COUNT: entry_count = value[6:0];
                REG_AD_ASC:      ad_rising   = value[0];
                REG_CORR_EN:     corr_on     = value[0];
                REG_REF_AD:      ref_ad      = value[15:0];
                default: ;
            endcase
        endfunction

        function int used_entries();
            int n;
            n = int'(entry_count);
            if (n < 2) n = 2;
            if (n > TBL_DEPTH) n = TBL_DEPTH;
            return n;
        endfunction

        // with correction on, every ad entry shifted mod 2^16 so entry 0 lands on the reference
        function logic [15:0] eff_ad(int i);
            logic [15:0] offset;
            offset = ref_ad - ad_col[0];
            return corr_on ? ad_col[i] + offset : ad_col[i];
        endfunction

        function longint floor_quot(longint num, longint den);
            longint quo;
            quo = num / den;
            if ((num % den) != 0 && num < 0) quo -= 1;
            return quo;
        endfunction

        function lookup_t interpolate(logic [1:0] op, logic [15:0] query);
            lookup_t res;
            int      n, l, r;
            longint  qv, fst, lst, n1, n2, n3, rv, e_l, e_r, a_l, a_r;
            n = used_entries();
            l = 0;
            r = 1;
            qv = longint'(query);
            res.clamped = 1'b0;
            res.tele_ad = eff_ad(0);
            res.wide_ad = eff_ad(n - 1);
            if (op == OP_AD2ANG)
            begin
                fst = longint'(eff_ad(0));
                lst = longint'(eff_ad(n - 1));
                if (ad_rising ? qv <= fst : qv >= fst)
                begin
                    res.clamped = (qv != fst);
                    res.value   = ang_col[0];
                    return res;
                end
                if (ad_rising ? qv >= lst : qv <= lst)
                begin
                    res.clamped = (qv != lst);
                    res.value   = ang_col[n - 1];
                    return res;
                end
                for (int i = 1; i < n; i++)
                begin
                    if (ad_rising ? qv <= longint'(eff_ad(i)) : qv >= longint'(eff_ad(i)))
                    begin
                        l = i - 1;
                        r = i;
                        break;
                    end
                end
                e_l = longint'(eff_ad(l));
                e_r = longint'(eff_ad(r));
                a_l = longint'(ang_col[l]);
                a_r = longint'(ang_col[r]);
                n1 = ad_rising ? e_r - qv : qv - e_r;
                n2 = ad_rising ? e_r - e_l : e_l - e_r;
                if (n2 <= 0)
                    res.value = ang_col[r];
                else
                begin
                    // angle column may fall, so the difference is signed
                    rv = a_r - floor_quot(n1 * (a_r - a_l), n2);
                    res.value = rv[15:0];
                end
            end
            else
            begin
                fst = longint'(ang_col[0]);
                lst = longint'(ang_col[n - 1]);
                if (qv >= lst)
                begin
                    res.clamped = (qv != lst);
                    res.value   = eff_ad(n - 1);
                    return res;
                end
                if (qv <= fst)
                begin
                    res.clamped = (qv != fst);
                    res.value   = eff_ad(0);
                    return res;
                end
                for (int i = 1; i < n; i++)
                begin
                    if (qv <= longint'(ang_col[i]))
                    begin
                        l = i - 1;
                        r = i;
                        break;
                    end
                end
                e_l = longint'(eff_ad(l));
                e_r = longint'(eff_ad(r));
                a_l = longint'(ang_col[l]);
                a_r = longint'(ang_col[r]);
                n1 = a_r - qv;
                n2 = a_r - a_l;
                if (n2 <= 0)
                    res.value = eff_ad(r);
                else
                begin
                    // rising ad rounds the step up, falling ad rounds it down
                    n3 = ad_rising ? e_r - e_l : e_l - e_r;
                    rv = ad_rising ? e_r + floor_quot(-(n1 * n3), n2)
                                   : e_r + floor_quot(n1 * n3, n2);
                    res.value = rv[15:0];
                end
            end
            return res;
        endfunction

        function void note_request(logic [1:0] op, logic [5:0] idx, logic [15:0] ad,
                                   logic [15:0] ang, logic [15:0] query);
            case (op)
                OP_LOAD:
                begin
                    ad_col[idx]  = ad;
                    ang_col[idx] = ang;
                end
                OP_AD2ANG, OP_ANG2AD: expected_lookups.push_back(interpolate(op, query));
                default: ;
            endcase
        endfunction

        function void check_result(logic [15:0] value, logic clamped, logic [15:0] tele_ad,
                                   logic [15:0] wide_ad);
            lookup_t want;
            if (expected_lookups.size() == 0)
            begin
                $error("result_value: expected none, actual %0d", value);
                errors++;
                return;
            end
            want = expected_lookups.pop_front();
            if (want.value !== value)
            begin
                $error("result_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (want.clamped !== clamped)
            begin
                $error("clamped: expected %0d, actual %0d", want.clamped, clamped);
                errors++;
            end
            if (want.tele_ad !== tele_ad)
            begin
                $error("telephoto_ad: expected %0d, actual %0d", want.tele_ad, tele_ad);
                errors++;
            end
            if (want.wide_ad !== wide_ad)
            begin
                $error("wide_ad: expected %0d, actual %0d", want.wide_ad, wide_ad);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_lookups.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // entry_index[5:0], entry_ad[21:6], entry_angle[37:22], query_value[53:38], zero
    logic [55:0] s_tdata;
    // operation[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // result_value[15:0], telephoto_ad[31:16], wide_ad[47:32]
    logic [47:0] m_tdata;
    // clamped[0]
    logic [0:0]  m_tuser;

    interp_scoreboard sb;
    int               src_idle_pct;
    int               rx_stall_pct;
    int               cycle_count;

    lens_position_angle_interpolator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lens_position_angle_interpolator_top_tb: done, errors");
            $finish;
        end
    end

    // result side: random backpressure, checked at the accepting edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[15:0], m_tuser[0], m_tdata[31:16], m_tdata[47:32]);
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(reg_idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic [1:0] op, input logic [5:0] idx,
                                input logic [15:0] ad, input logic [15:0] ang,
                                input logic [15:0] query);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, query, ang, ad, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, idx, ad, ang, query);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        while (sb.outstanding() != 0) @(negedge clk);
        // a load or dropped request may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // monotonic tables mostly, some with flat steps, some pure noise
    task automatic load_table(input int n);
        logic [15:0] ad_v [TBL_DEPTH];
        logic [15:0] ang_v [TBL_DEPTH];
        int          shape, ad_step, ang_step;
        bit          ang_falls;
        shape     = $urandom_range(0, 99);
        ang_falls = ($urandom_range(0, 99) < 20);
        ad_v[0]   = 16'($urandom_range(0, 4095));
        ang_v[0]  = 16'($urandom_range(0, 4095));
        ad_step   = $urandom_range(1, (65535 - ad_v[0]) / (n - 1));
        ang_step  = $urandom_range(1, (65535 - ang_v[0]) / (n - 1));
        for (int i = 1; i < n; i++)
        begin
            ad_v[i]  = 16'(ad_v[i - 1] + $urandom_range((shape >= 70) ? 0 : 1, ad_step));
            ang_v[i] = 16'(ang_v[i - 1] + $urandom_range((shape >= 70) ? 0 : 1, ang_step));
            if (shape >= 85)
            begin
                ad_v[i]  = 16'($urandom);
                ang_v[i] = 16'($urandom);
            end
        end
        for (int i = 0; i < n; i++)
            send_request(OP_LOAD, 6'(i), ad_v[sb.ad_rising ? i : n - 1 - i],
                         ang_v[ang_falls ? n - 1 - i : i], 16'($urandom));
    endtask

    function automatic logic [15:0] pick_query(input logic [1:0] op);
        int n, i, a, b;
        n = sb.used_entries();
        i = $urandom_range(0, n - 2);
        if (op == OP_AD2ANG)
        begin
            a = int'(sb.eff_ad(i));
            b = int'(sb.eff_ad(i + 1));
        end
        else
        begin
            a = int'(sb.ang_col[i]);
            b = int'(sb.ang_col[i + 1]);
        end
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            3: return 16'(a);
            4: return 16'(a - 1);
            5: return 16'(b + 1);
            6: return 16'(b);
            default: return (a < b) ? 16'($urandom_range(a, b)) : 16'($urandom_range(b, a));
        endcase
    endfunction

    initial
    begin
        int          count, sel;
        bit          rising, corr;
        logic [15:0] ref_val;
        logic [1:0]  op;
        sb = new();
        cycle_count  = 0;
        src_idle_pct = 0;
        rx_stall_pct = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: two entries, ad falling, no correction
        send_request(OP_LOAD,   6'd0, 16'hFFFF, 16'd0,     16'd0);
        send_request(OP_LOAD,   6'd1, 16'd0,    16'hFFFF,  16'd0);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'hFFFF);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd0);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd32768);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd1);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd0);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'hFFFF);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd12345);
        send_request(OP_NONE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_LOAD,   6'd0, 16'd40000, 16'd1000, 16'd0);
        send_request(OP_LOAD,   6'd1, 16'd20000, 16'd9000, 16'd0);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd50000);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd10000);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd30001);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd500);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd9500);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd4321);
        // angle column falling along the table
        send_request(OP_LOAD,   6'd1, 16'd20000, 16'd100,  16'd0);
        send_request(OP_AD2ANG, 6'd0, 16'd0,    16'd0,     16'd25000);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd500);
        send_request(OP_ANG2AD, 6'd0, 16'd0,    16'd0,     16'd50);
        s_tvalid <= 1'b0;
        wait_drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    count = 2; rising = 1'b0; corr = 1'b0; ref_val = 16'd0;
                end
                1:
                begin
                    count = 64; rising = 1'b1; corr = 1'b1; ref_val = 16'hFFFF;
                end
                2:
                begin
                    count = 0; rising = 1'b0; corr = 1'b1; ref_val = 16'd0;
                end
                3:
                begin
                    count = 127; rising = 1'b1; corr = 1'b0; ref_val = 16'($urandom);
                end
                4:
                begin
                    count = 1; rising = 1'b1; corr = 1'b1; ref_val = 16'($urandom);
                end
                default:
                begin
                    sel = $urandom_range(0, 99);
                    // mostly short tables, since the scan time grows with the count
                    count = (sel < 70) ? $urandom_range(2, 16) :
                            (sel < 90) ? $urandom_range(17, 64) :
                            (sel < 95) ? $urandom_range(65, 127) : $urandom_range(0, 1);
                    rising  = 1'($urandom_range(0, 1));
                    corr    = 1'($urandom_range(0, 1));
                    ref_val = 16'($urandom);
                end
            endcase
            case (phase % 4)
                0:
                begin
                    src_idle_pct = 0;  rx_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 68; rx_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;  rx_stall_pct = 68;
                end
                default:
                begin
                    src_idle_pct = 7;  rx_stall_pct = 7;
                end
            endcase
            apb_write(REG_ENTRY_COUNT, 32'(count));
            apb_write(REG_AD_ASC,      32'(rising));
            apb_write(REG_CORR_EN,     32'(corr));
            apb_write(REG_REF_AD,      32'(ref_val));
            load_table(sb.used_entries());

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 4)
                    send_request(OP_LOAD, 6'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                else if (sel < 6)
                    send_request(OP_NONE, 6'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                else if (sel < 7)
                begin
                    s_tvalid <= 1'b0;
                    wait_drain();
                end
                else
                begin
                    op = $urandom_range(0, 1) ? OP_AD2ANG : OP_ANG2AD;
                    send_request(op, 6'($urandom), 16'($urandom), 16'($urandom),
                                 pick_query(op));
                end
            end
            s_tvalid <= 1'b0;
            wait_drain();
        end

        if (sb.errors == 0)
            $display("lens_position_angle_interpolator_top_tb: done, clean");
        else
            $display("lens_position_angle_interpolator_top_tb: done, errors");
        $finish;
    end

endmodule
